// File: sv/assert_macros.svh
// concurrent assertion helpers, compiled out for synthesis
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define ASSERT_CLK(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("assertion failed");
`define ASSERT_NEVER(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(prop)) \
    else $error("forbidden condition seen");
`else
`define ASSERT_CLK(lbl, prop)
`define ASSERT_NEVER(lbl, prop)
`endif

`endif

// File: sv/sctc_pkg.sv
`default_nettype none

package sctc_pkg;

  localparam int unsigned MAX_TREES_DEF     = 2048;
  localparam int unsigned TREE_DEPTH_DEF    = 2;
  localparam int unsigned FEATURE_COUNT_DEF = 4096;

  localparam int unsigned CNT_W    = 12;
  localparam int unsigned MARGIN_W = 15;
  localparam int unsigned CFG_W    = 15;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned W_W      = 16;
  localparam int unsigned FIDX_W   = 12;
  localparam int unsigned SCORE_O_W = 28;
  localparam int unsigned WSUM_O_W  = 27;

  localparam logic [CNT_W-1:0]    TREE_COUNT_RST    = CNT_W'(2000);
  localparam logic [CNT_W-1:0]    MIN_TREES_RST     = CNT_W'(40);
  localparam logic [MARGIN_W-1:0] REJECT_MARGIN_RST = MARGIN_W'(3277);

  localparam longint SCORE_O_MAX = (longint'(1) <<< (SCORE_O_W - 1)) - 1;
  localparam longint SCORE_O_MIN = -(longint'(1) <<< (SCORE_O_W - 1));
  localparam longint WSUM_O_MAX  = (longint'(1) <<< WSUM_O_W) - 1;

  typedef enum logic [1:0] {
    MODE_NODE = 2'd0,
    MODE_FEAT = 2'd1,
    MODE_EVAL = 2'd2
  } mode_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TREE_COUNT    = 2'd0,
    CFG_MIN_TREES     = 2'd1,
    CFG_REJECT_MARGIN = 2'd2
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ROOT,
    ST_NODE,
    ST_FEAT,
    ST_ACC,
    ST_NEXT,
    ST_FIN
  } state_e;

  typedef struct packed {
    logic              leaf;
    logic              vote;
    logic [FIDX_W-1:0] feat;
    logic [15:0]       thr;
  } node_t;

  typedef struct packed {
    logic [1:0]        mode;
    logic [10:0]       tree_index;
    logic [2:0]        node_index;
    logic              node_is_leaf;
    logic              leaf_votes_positive;
    logic [FIDX_W-1:0] feature_index;
    logic [15:0]       node_threshold;
    logic [W_W-1:0]    tree_weight;
    logic [15:0]       feature_value;
  } in_req_t;

  typedef struct packed {
    logic signed [SCORE_O_W-1:0] score_sum;
    logic [WSUM_O_W-1:0]         weight_sum;
    logic [CNT_W-1:0]            trees_used;
    logic                        is_positive;
    logic                        rejected_early;
  } out_rsp_t;

endpackage

`default_nettype wire

// File: sv/soft_cascade_tree_classifier.sv
// loads (node, feature): one request a cycle while idle, written at the accepting edge
// evaluation: per used tree, a root read, a node and a feature step per descent, then accumulate
// each descent is two dependent memory reads: feature then child node
// reset sets state to idle and configuration to defaults; node, weight and feature memories are not cleared
// a finished result waits in its output register while loads are still taken
`default_nettype none

`include "assert_macros.svh"

module soft_cascade_tree_classifier #(
  parameter int unsigned MAX_TREES     = sctc_pkg::MAX_TREES_DEF,
  parameter int unsigned TREE_DEPTH    = sctc_pkg::TREE_DEPTH_DEF,
  parameter int unsigned FEATURE_COUNT = sctc_pkg::FEATURE_COUNT_DEF
) (
  input  wire                            clk_i,
  input  wire                            rst_ni,
  input  wire                            cfg_we_i,
  input  wire [sctc_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire [sctc_pkg::CFG_W-1:0]      cfg_data_i,
  input  wire                            in_valid_i,
  output logic                           in_ready_o,
  input  wire sctc_pkg::in_req_t         in_req_i,
  output logic                           out_valid_o,
  input  wire                            out_ready_i,
  output sctc_pkg::out_rsp_t             out_rsp_o
);

  import sctc_pkg::*;

  localparam int unsigned NODES      = (2 << TREE_DEPTH) - 1;
  localparam int unsigned NODE_DEPTH = MAX_TREES * NODES;
  localparam int unsigned NODE_AW    = $clog2(NODE_DEPTH);
  localparam int unsigned TREE_AW    = (MAX_TREES > 1) ? $clog2(MAX_TREES) : 1;
  localparam int unsigned TREE_W     = $clog2(MAX_TREES + 1);
  localparam int unsigned FEAT_AW    = (FEATURE_COUNT > 1) ? $clog2(FEATURE_COUNT) : 1;
  localparam int unsigned NODE_W     = $clog2(NODES);
  localparam int unsigned LVL_W      = $clog2(TREE_DEPTH + 1);
  localparam int unsigned WSUM_W     = W_W + TREE_W;
  localparam int unsigned SCORE_W    = WSUM_W + 1;
  localparam int unsigned PROD_W     = MARGIN_W + W_W;
  localparam int unsigned CONF_W     = SCORE_W + MARGIN_W + 1;

  // memories
  node_t          node_mem [NODE_DEPTH];
  logic [W_W-1:0] wgt_mem  [MAX_TREES];
  logic [15:0]    feat_mem [FEATURE_COUNT];

  node_t          node_rd_q;
  logic [W_W-1:0] wgt_rd_q;
  logic [15:0]    feat_rd_q;

  // control
  state_e state_q, state_d;
  logic   out_valid_q;
  logic [CNT_W-1:0]    tree_count_q, min_trees_q;
  logic [MARGIN_W-1:0] margin_q;

  // walk state
  logic [TREE_W-1:0]          t_q, count_q, first_q;
  logic [NODE_AW-1:0]         base_q;
  logic [NODE_W-1:0]          n_q;
  logic [LVL_W-1:0]           level_q;
  logic [PROD_W-1:0]          prod_q;
  logic signed [SCORE_W-1:0]  score_q;
  logic [WSUM_W-1:0]          wsum_q;
  logic signed [CONF_W-1:0]   conf_q;
  out_rsp_t                   out_q;

  // combinational
  logic               in_acc, start, out_load, at_leaf, go_on;
  logic [TREE_W-1:0]  eff_count, eff_first;
  logic               node_we, wgt_we, feat_we;
  logic [NODE_AW-1:0] node_waddr, node_raddr;
  logic [TREE_AW-1:0] wgt_waddr;
  logic [FEAT_AW-1:0] feat_waddr, feat_raddr;
  logic               node_re, wgt_re, feat_re;
  node_t              node_wdata;
  logic [15:0]        fv;
  logic [NODE_W-1:0]  child;
  logic signed [SCORE_W-1:0] w_s;
  logic signed [CONF_W-1:0]  vote_term, prod_s;
  out_rsp_t           out_d;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign in_acc      = in_valid_i && in_ready_o;
  assign start       = in_acc && (in_req_i.mode == MODE_EVAL);
  assign out_load    = (state_q == ST_FIN) && (!out_valid_q || out_ready_i);
  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

  assign eff_count = (32'(tree_count_q) > 32'(MAX_TREES)) ? TREE_W'(MAX_TREES)
                                                          : TREE_W'(tree_count_q);
  assign eff_first = (32'(min_trees_q) > 32'(eff_count)) ? eff_count
                                                         : TREE_W'(min_trees_q);

  assign at_leaf = node_rd_q.leaf || (level_q == LVL_W'(TREE_DEPTH));
  assign go_on   = (t_q < count_q) &&
                   ((t_q < first_q) || ((wsum_q != '0) && (conf_q > 0)));

  assign fv    = (32'(node_rd_q.feat) < 32'(FEATURE_COUNT)) ? feat_rd_q : '0;
  assign child = NODE_W'({1'b0, n_q, 1'b0} + ((fv < node_rd_q.thr) ? 1 : 2));

  assign w_s       = $signed(SCORE_W'(wgt_rd_q));
  assign vote_term = $signed(CONF_W'(wgt_rd_q) << MARGIN_W);
  assign prod_s    = $signed(CONF_W'(prod_q));

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (start) begin
          state_d = (eff_first == '0) ? ST_FIN : ST_ROOT;
        end
      end
      ST_ROOT: state_d = ST_NODE;
      ST_NODE: state_d = at_leaf ? ST_ACC : ST_FEAT;
      ST_FEAT: state_d = ST_NODE;
      ST_ACC:  state_d = ST_NEXT;
      ST_NEXT: state_d = go_on ? ST_ROOT : ST_FIN;
      ST_FIN: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // memory port control
  always_comb begin
    node_we    = 1'b0;
    wgt_we     = 1'b0;
    feat_we    = 1'b0;
    node_re    = 1'b0;
    wgt_re     = 1'b0;
    feat_re    = 1'b0;
    node_raddr = base_q;
    feat_raddr = FEAT_AW'(node_rd_q.feat);
    node_waddr = NODE_AW'(32'(in_req_i.tree_index) * 32'(NODES) +
                          32'(in_req_i.node_index));
    wgt_waddr  = TREE_AW'(in_req_i.tree_index);
    feat_waddr = FEAT_AW'(in_req_i.feature_index);
    node_wdata = '{leaf: in_req_i.node_is_leaf, vote: in_req_i.leaf_votes_positive,
                   feat: in_req_i.feature_index, thr: in_req_i.node_threshold};
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc && (in_req_i.mode == MODE_NODE) &&
            (32'(in_req_i.tree_index) < 32'(MAX_TREES)) &&
            (32'(in_req_i.node_index) < 32'(NODES))) begin
          node_we = 1'b1;
          wgt_we  = (in_req_i.node_index == '0);
        end
        if (in_acc && (in_req_i.mode == MODE_FEAT) &&
            (32'(in_req_i.feature_index) < 32'(FEATURE_COUNT))) begin
          feat_we = 1'b1;
        end
      end
      ST_ROOT: begin
        node_re = 1'b1;
        wgt_re  = 1'b1;
      end
      ST_NODE: feat_re = !at_leaf;
      ST_FEAT: begin
        node_re    = 1'b1;
        node_raddr = base_q + NODE_AW'(child);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (node_we) begin
      node_mem[node_waddr] <= node_wdata;
    end
    if (node_re) begin
      node_rd_q <= node_mem[node_raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (wgt_we) begin
      wgt_mem[wgt_waddr] <= in_req_i.tree_weight;
    end
    if (wgt_re) begin
      wgt_rd_q <= wgt_mem[t_q[TREE_AW-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (feat_we) begin
      feat_mem[feat_waddr] <= in_req_i.feature_value;
    end
    if (feat_re) begin
      feat_rd_q <= feat_mem[feat_raddr];
    end
  end

  // result formatting with saturation
  always_comb begin
    longint sc;
    longint ws;
    sc = longint'(score_q);
    ws = longint'(wsum_q);
    if (sc > SCORE_O_MAX) begin
      sc = SCORE_O_MAX;
    end else if (sc < SCORE_O_MIN) begin
      sc = SCORE_O_MIN;
    end
    if (ws > WSUM_O_MAX) begin
      ws = WSUM_O_MAX;
    end
    out_d.score_sum      = SCORE_O_W'(sc);
    out_d.weight_sum     = WSUM_O_W'(ws);
    out_d.trees_used     = CNT_W'(t_q);
    out_d.is_positive    = (score_q > 0);
    out_d.rejected_early = (t_q < count_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      out_valid_q  <= 1'b0;
      tree_count_q <= TREE_COUNT_RST;
      min_trees_q  <= MIN_TREES_RST;
      margin_q     <= REJECT_MARGIN_RST;
    end else begin
      state_q <= state_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_TREE_COUNT:    tree_count_q <= cfg_data_i[CNT_W-1:0];
          CFG_MIN_TREES:     min_trees_q  <= cfg_data_i[CNT_W-1:0];
          CFG_REJECT_MARGIN: margin_q     <= cfg_data_i[MARGIN_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start) begin
      count_q <= eff_count;
      first_q <= eff_first;
      t_q     <= '0;
      base_q  <= '0;
      score_q <= '0;
      wsum_q  <= '0;
      conf_q  <= '0;
    end
    if (state_q == ST_ROOT) begin
      n_q     <= '0;
      level_q <= '0;
    end
    if (state_q == ST_NODE) begin
      prod_q <= PROD_W'(margin_q) * PROD_W'(wgt_rd_q);
    end
    if (state_q == ST_FEAT) begin
      n_q     <= child;
      level_q <= level_q + LVL_W'(1);
    end
    if (state_q == ST_ACC) begin
      score_q <= node_rd_q.vote ? (score_q + w_s) : (score_q - w_s);
      wsum_q  <= wsum_q + WSUM_W'(wgt_rd_q);
      conf_q  <= conf_q + (node_rd_q.vote ? vote_term : -vote_term) + prod_s;
      t_q     <= t_q + TREE_W'(1);
      base_q  <= base_q + NODE_AW'(NODES);
    end
    if (out_load) begin
      out_q <= out_d;
    end
  end

  `ASSERT_CLK(a_result_from_fin, $rose(out_valid_q) |-> $past(state_q == ST_FIN))
  `ASSERT_CLK(a_walk_depth, (state_q == ST_NODE) |-> (level_q <= LVL_W'(TREE_DEPTH)))
  `ASSERT_NEVER(a_past_count, (state_q == ST_NEXT) && (t_q > count_q))

endmodule

`default_nettype wire
